// File: design/sdat_pkg.sv
// ----------------------------------------------------------------------------
// sdat_pkg
// Types and constants for the session deadline aging table.
// ----------------------------------------------------------------------------
package sdat_pkg;

  localparam int Buckets   = 128;
  localparam int Ways      = 4;
  localparam int BucketW   = $clog2(Buckets);
  localparam int WayW      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int FillW     = $clog2(Ways + 1);
  localparam int EntryW    = 96;
  localparam int RowW      = EntryW * Ways + FillW;

  typedef enum logic [1:0] {
    OP_REFRESH = 2'd0,
    OP_GET     = 2'd1,
    OP_DELETE  = 2'd2,
    OP_AGE     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] account_id;
    logic [31:0] verify_duration;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] found_deadline;
    logic [31:0] found_ping;
    logic        expired_valid;
    logic [31:0] expired_account;
    logic        overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WRITE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic rd;
    logic commit;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

endpackage

// File: design/sdat_ram.sv
// ----------------------------------------------------------------------------
// sdat_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sdat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write, and registered read of the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/sdat_ctrl.sv
// ----------------------------------------------------------------------------
// sdat_ctrl
// Controller: clearing pass after reset, then read / write per item.
// ----------------------------------------------------------------------------
module sdat_ctrl import sdat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
        cmd.rd      = start;
      end
      ST_READ:  busy = 1'b1;
      ST_WRITE: cmd.commit = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

// File: design/sdat_dp.sv
// ----------------------------------------------------------------------------
// sdat_dp
// Datapath: bucket row memory, way compare, row update and result register.
// ----------------------------------------------------------------------------
module sdat_dp import sdat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_item_t  in_item,
  input  logic      enabled,
  output logic      out_valid,
  output out_item_t out_item
);

  in_item_t            item_r;
  logic [BucketW-1:0]  scan_r, scan_nxt;
  logic [BucketW-1:0]  clr_r;
  logic [BucketW-1:0]  bkt_r, bkt_in, addr;
  logic [RowW-1:0]     row_rd, row_wr;
  logic                we;
  logic                vld_r;
  out_item_t           res_r, res;

  logic [31:0]         acc [Ways];
  logic [31:0]         ddl [Ways];
  logic [31:0]         png [Ways];
  logic [FillW-1:0]    fill;
  logic [Ways-1:0]     hit, exp_w;
  logic                any_hit, any_exp;
  logic [WayW-1:0]     hit_w, exp_i, rm_w;
  logic                do_rm, do_app;
  logic [31:0]         n_acc [Ways];
  logic [31:0]         n_ddl [Ways];
  logic [31:0]         n_png [Ways];
  logic [FillW-1:0]    n_fill, f2;

  // Bucket from account or scan pointer
  assign bkt_in = (in_item.operation == OP_AGE) ? scan_r : in_item.account_id[BucketW-1:0];
  assign addr   = cmd.clear ? clr_r : (cmd.rd ? bkt_in : bkt_r);
  assign we     = cmd.clear || (cmd.commit && enabled);
  assign sts.clear_done = cmd.clear && (clr_r == BucketW'(Buckets - 1));

  sdat_ram #(.Width(RowW), .Depth(Buckets)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(cmd.clear ? '0 : row_wr),
    .rdata(row_rd)
  );

  // Unpack row and compare ways
  always_comb begin
    for (int i = 0; i < Ways; i++) begin
      acc[i]   = row_rd[i*EntryW +: 32];
      ddl[i]   = row_rd[i*EntryW + 32 +: 32];
      png[i]   = row_rd[i*EntryW + 64 +: 32];
      hit[i]   = (FillW'(i) < fill) && (acc[i] == item_r.account_id);
      exp_w[i] = (FillW'(i) < fill) && (item_r.now_ms > ddl[i]);
    end
  end
  assign fill = row_rd[RowW-1 -: FillW];

  // First hit and first expiry
  always_comb begin
    any_hit = 1'b0;
    any_exp = 1'b0;
    hit_w   = '0;
    exp_i   = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_w   = WayW'(i);
      end
      if (exp_w[i]) begin
        any_exp = 1'b1;
        exp_i   = WayW'(i);
      end
    end
  end

  // Build new row: remove then append
  always_comb begin
    do_rm  = 1'b0;
    rm_w   = hit_w;
    res    = '0;
    unique case (op_t'(item_r.operation))
      OP_REFRESH, OP_DELETE: do_rm = any_hit;
      OP_AGE: begin
        do_rm = any_exp;
        rm_w  = exp_i;
      end
      OP_GET: do_rm = 1'b0;
      default: do_rm = 1'b0;
    endcase
    for (int i = 0; i < Ways; i++) begin
      if (do_rm && (WayW'(i) >= rm_w) && (i + 1 < Ways)) begin
        n_acc[i] = acc[(i + 1) % Ways];
        n_ddl[i] = ddl[(i + 1) % Ways];
        n_png[i] = png[(i + 1) % Ways];
      end else begin
        n_acc[i] = acc[i];
        n_ddl[i] = ddl[i];
        n_png[i] = png[i];
      end
    end
    f2     = do_rm ? fill - FillW'(1) : fill;
    do_app = (item_r.operation == OP_REFRESH) && (f2 < FillW'(Ways));
    for (int i = 0; i < Ways; i++) begin
      if (do_app && (FillW'(i) == f2)) begin
        n_acc[i] = item_r.account_id;
        n_ddl[i] = item_r.now_ms + item_r.verify_duration;
        n_png[i] = item_r.now_ms;
      end
    end
    n_fill = do_app ? f2 + FillW'(1) : f2;
    if (enabled) begin
      unique case (op_t'(item_r.operation))
        OP_REFRESH: res.overflow = !do_app;
        OP_GET: begin
          res.found = any_hit;
          if (any_hit) begin
            res.found_deadline = ddl[hit_w];
            res.found_ping     = png[hit_w];
          end
        end
        OP_AGE: begin
          res.expired_valid = any_exp;
          if (any_exp) res.expired_account = acc[exp_i];
        end
        OP_DELETE: res = '0;
        default: res = '0;
      endcase
    end
  end

  always_comb begin
    row_wr = '0;
    row_wr[RowW-1 -: FillW] = n_fill;
    for (int i = 0; i < Ways; i++) begin
      row_wr[i*EntryW +: EntryW] = {n_png[i], n_ddl[i], n_acc[i]};
    end
  end

  // Advance scan pointer on an enabled age item
  assign scan_nxt = (scan_r == BucketW'(Buckets - 1)) ? '0 : scan_r + BucketW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      clr_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      vld_r <= cmd.commit;
      if (cmd.clear) clr_r <= clr_r + BucketW'(1);
      if (cmd.commit && enabled && item_r.operation == OP_AGE) scan_r <= scan_nxt;
    end
  end

  // Hold item and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
      bkt_r  <= bkt_in;
    end
    if (cmd.commit) res_r <= res;
  end

  assign out_valid = vld_r;
  assign out_item  = res_r;

endmodule

// File: design/session_deadline_aging_table.sv
// ----------------------------------------------------------------------------
// session_deadline_aging_table
// Hashed session table with deadline aging, one bucket row per memory word.
// ----------------------------------------------------------------------------
// The result strobe is registered from the commit of the write state, which follows
// the read state. Busy stays high through the row read and write-back, so a new item
// is taken only in idle. Reset: synchronous; a clearing pass zeroes every bucket row,
// busy stays high meanwhile. The receiver cannot stall results.
module session_deadline_aging_table import sdat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output logic      out_strobe,
  output out_item_t out_item
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    enabled_r;

  // Hold the enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_we) begin
      enabled_r <= cfg_wdata;
    end
  end

  sdat_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  sdat_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .enabled  (enabled_r),
    .out_valid(out_strobe),
    .out_item (out_item)
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Session deadline aging table testbench
// Drives refresh, get, delete and age items through the start/busy handshake,
// predicts every result with a behavioural copy of the table and compares
// each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sdat_pkg::*;

  localparam int CycleLimit = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      out_strobe;
  out_item_t out_item;

  session_deadline_aging_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_strobe(out_strobe),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  // Predicted table contents
  logic [31:0] tbl_acct [Buckets][Ways];
  logic [31:0] tbl_dl   [Buckets][Ways];
  logic [31:0] tbl_ping [Buckets][Ways];
  int          tbl_fill [Buckets];
  int          aging_ptr;
  logic        table_on;

  out_item_t pending_results [$];
  int        errors = 0;
  int        cycles = 0;
  int        idle_pct = 0;

  // Account pool: few buckets so that collisions and overflow occur
  logic [31:0] acct_pool [16];

  function automatic void drop_way(int b, int w);
    for (int k = w; k + 1 < tbl_fill[b]; k++) begin
      tbl_acct[b][k] = tbl_acct[b][k+1];
      tbl_dl[b][k]   = tbl_dl[b][k+1];
      tbl_ping[b][k] = tbl_ping[b][k+1];
    end
    tbl_fill[b]--;
  endfunction

  function automatic int way_of(int b, logic [31:0] a);
    for (int w = 0; w < tbl_fill[b]; w++)
      if (tbl_acct[b][w] == a) return w;
    return -1;
  endfunction

  // Work out the result of one item and advance the predicted table
  function automatic out_item_t table_response(in_item_t it);
    out_item_t r;
    int b, w;
    r = '0;
    b = it.account_id % Buckets;
    if (!table_on) return r;
    case (op_t'(it.operation))
      OP_REFRESH: begin
        w = way_of(b, it.account_id);
        if (w >= 0) drop_way(b, w);
        if (tbl_fill[b] >= Ways) r.overflow = 1'b1;
        else begin
          tbl_acct[b][tbl_fill[b]] = it.account_id;
          tbl_ping[b][tbl_fill[b]] = it.now_ms;
          tbl_dl[b][tbl_fill[b]]   = it.now_ms + it.verify_duration;
          tbl_fill[b]++;
        end
      end
      OP_GET: begin
        w = way_of(b, it.account_id);
        if (w >= 0) begin
          r.found = 1'b1;
          r.found_deadline = tbl_dl[b][w];
          r.found_ping = tbl_ping[b][w];
        end
      end
      OP_DELETE: begin
        w = way_of(b, it.account_id);
        if (w >= 0) drop_way(b, w);
      end
      default: begin
        for (int k = 0; k < tbl_fill[aging_ptr]; k++)
          if (it.now_ms > tbl_dl[aging_ptr][k]) begin
            r.expired_valid = 1'b1;
            r.expired_account = tbl_acct[aging_ptr][k];
            drop_way(aging_ptr, k);
            break;
          end
        aging_ptr = (aging_ptr + 1) % Buckets;
      end
    endcase
    return r;
  endfunction

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (e.found !== out_item.found)
          $display("%0t: found exp %h got %h", $time, e.found, out_item.found);
        if (e.found_deadline !== out_item.found_deadline)
          $display("%0t: found_deadline exp %h got %h", $time,
                   e.found_deadline, out_item.found_deadline);
        if (e.found_ping !== out_item.found_ping)
          $display("%0t: found_ping exp %h got %h", $time,
                   e.found_ping, out_item.found_ping);
        if (e.expired_valid !== out_item.expired_valid)
          $display("%0t: expired_valid exp %h got %h", $time,
                   e.expired_valid, out_item.expired_valid);
        if (e.expired_account !== out_item.expired_account)
          $display("%0t: expired_account exp %h got %h", $time,
                   e.expired_account, out_item.expired_account);
        if (e.overflow !== out_item.overflow)
          $display("%0t: overflow exp %h got %h", $time,
                   e.overflow, out_item.overflow);
        if (e !== out_item) errors++;
      end
    end
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Hand one item to the block and queue its prediction
  task automatic send_item(in_item_t it);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.insert(pending_results.size(), table_response(it));
    start <= 1'b0;
  endtask

  // Wait for the block to drain, then write the enable register
  task automatic set_enable(logic v);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    table_on = v;
  endtask

  function automatic in_item_t mk(op_t op, logic [31:0] a, logic [31:0] d,
                                  logic [31:0] n);
    in_item_t it;
    it.operation = op;
    it.account_id = a;
    it.verify_duration = d;
    it.now_ms = n;
    return it;
  endfunction

  function automatic in_item_t random_item(logic [31:0] clock_ms);
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.operation = op_t'($urandom_range(3));
    it.account_id = (r < 85) ? acct_pool[$urandom_range(15)] : $urandom();
    it.verify_duration = (r < 90) ? $urandom_range(400) : $urandom();
    it.now_ms = (r < 92) ? clock_ms : $urandom();
    return it;
  endfunction

  // Directed table: item and, where obvious, the known result
  typedef struct {
    in_item_t  it;
    logic      known;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Append one row to the directed table
  function automatic void add_row(in_item_t it, logic known, out_item_t res);
    dir_row_t row;
    row.it    = it;
    row.known = known;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    logic [31:0] clock_ms;
    out_item_t   z;
    z = '0;
    foreach (tbl_fill[i]) tbl_fill[i] = 0;
    aging_ptr = 0;
    table_on = 1'b0;
    foreach (acct_pool[i])
      acct_pool[i] = ($urandom() & 32'hFFFF_FF80) | (i % 3) | ((i & 1) << 6);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled: ignored, all-zero result
    send_item(mk(OP_REFRESH, 32'd5, 32'd100, 32'd0));
    send_item(mk(OP_AGE, 32'd0, 32'd0, 32'hFFFF_FFFF));
    set_enable(1'b1);

    add_row(mk(OP_GET, 32'd5, 32'd0, 32'd0), 1'b1, z);
    add_row(mk(OP_REFRESH, 32'd5, 32'd100, 32'd10), 1'b0, z);
    add_row(mk(OP_GET, 32'd5, 32'd0, 32'd20), 1'b0, z);
    // Deadline wraps at 32 bits
    add_row(mk(OP_REFRESH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, z);
    add_row(mk(OP_GET, 32'hFFFF_FFFF, 32'd0, 32'd0), 1'b0, z);
    // Fill bucket 5, then overflow
    add_row(mk(OP_REFRESH, 32'd133, 32'd0, 32'd0), 1'b0, z);
    add_row(mk(OP_REFRESH, 32'd261, 32'd50, 32'd0), 1'b0, z);
    add_row(mk(OP_REFRESH, 32'd389, 32'd7, 32'd1), 1'b0, z);
    add_row(mk(OP_REFRESH, 32'd517, 32'd7, 32'd1), 1'b1,
            '{overflow: 1'b1, default: '0});
    // Refresh of a present account in a full bucket succeeds
    add_row(mk(OP_REFRESH, 32'd133, 32'd9, 32'd2), 1'b1, z);
    add_row(mk(OP_DELETE, 32'd261, 32'd0, 32'd0), 1'b1, z);
    add_row(mk(OP_DELETE, 32'd261, 32'd0, 32'd0), 1'b1, z);
    add_row(mk(OP_GET, 32'd261, 32'd0, 32'd0), 1'b1, z);
    // Ageing: empty buckets still advance, then bucket 5 expires its first way
    for (int i = 0; i < 6; i++)
      add_row(mk(OP_AGE, 32'd0, 32'd0, 32'hFFFF_FFFF), 1'b0, z);
    add_row(mk(OP_REFRESH, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555), 1'b0, z);
    add_row(mk(OP_GET, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd0), 1'b0, z);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        out_item_t p;
        send_item(dir_rows[i].it);
        p = pending_results[$];
        if (p !== dir_rows[i].res) begin
          $display("%0t: directed row %0d exp %h got %h", $time, i,
                   dir_rows[i].res, p);
          errors++;
        end
      end else send_item(dir_rows[i].it);
    end

    // Random phases with different sender idling, enable toggled off and on after the third
    clock_ms = 32'd1000;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 65;
        default: idle_pct = 13;
      endcase
      for (int i = 0; i < 270; i++) begin
        clock_ms += $urandom_range(30);
        send_item(random_item(clock_ms));
        if (i == 100) while (pending_results.size() != 0) @(posedge clk);
      end
      if (ph == 2) begin
        set_enable(1'b0);
        for (int i = 0; i < 10; i++) send_item(random_item(clock_ms));
        set_enable(1'b1);
      end
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
